[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL (included by integer_list_store).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk_i edge, switched off while rst_ni is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Implication form: consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

[design/ils_pkg.sv]
// ----------------------------------------------------------------------------
// ils_pkg
// Types and codes for the integer list store.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned STAT_W = 2;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GET    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SET    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic [POS_W-1:0]         first_match_res;
    logic [CNT_W-1:0]         match_count;
    logic [CNT_W-1:0]         length;
    logic [STAT_W-1:0]        status;
  } res_t;

  // Controller to ring of cells
  typedef struct packed {
    logic              shift;
    logic [DATA_W-1:0] tail;
  } ring_ctl_t;

endpackage

`default_nettype wire

[design/ils_cell.sv]
// ----------------------------------------------------------------------------
// ils_cell
// One storage cell of the ring: holds a word, loads its input word on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_cell #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] word_q;

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= d_i;
    end
  end

  assign q_o = word_q;

endmodule

`default_nettype wire

[design/ils_ctrl.sv]
// ----------------------------------------------------------------------------
// ils_ctrl
// Sequencer for the list: decodes a command, rotates the ring once through
// the head cell when the command needs it and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_ctrl #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire ils_pkg::req_t              req_i,
  input  wire logic [ils_pkg::DATA_W-1:0] head_i,
  output ils_pkg::ring_ctl_t              ring_o,
  output logic                            done_o,
  output ils_pkg::res_t                   res_o
);

  localparam int unsigned KW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = ils_pkg::POS_W;
  localparam int unsigned IW = (KW > PW) ? KW : PW;
  localparam int unsigned FW = (CW > PW) ? CW : PW;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                         state_q;
  logic [KW-1:0]                  step_q;
  logic [CW-1:0]                  fill_q;
  logic [ils_pkg::MODE_W-1:0]     op_q;
  logic [PW-1:0]                  pos_q;
  logic [ils_pkg::DATA_W-1:0]     val_q;
  logic [ils_pkg::DATA_W-1:0]     rd_q;
  logic                           found_q;
  logic [KW-1:0]                  first_q;
  logic [CW-1:0]                  cnt_q;
  logic                           done_q;
  ils_pkg::res_t                  res_q;

  logic                           at_pos;
  logic                           at_fill;
  logic                           step_valid;
  logic                           hit;
  logic                           last_step;
  logic                           rw_op;
  logic                           write_here;
  logic                           pos_ok;
  logic                           list_full;
  logic [ils_pkg::DATA_W-1:0]     rd_n;
  logic                           found_n;
  logic [KW-1:0]                  first_n;
  logic [CW-1:0]                  cnt_n;
  logic [CW-1:0]                  fill_n;
  logic                           scan_go;
  logic                           done_d;
  ils_pkg::res_t                  res_d;

  // Head cell holds logical entry step_q during a rotation
  always_comb begin
    at_pos     = IW'(step_q) == IW'(pos_q);
    at_fill    = CW'(step_q) == fill_q;
    step_valid = CW'(step_q) < fill_q;
    hit        = (op_q == ils_pkg::MODE_FIND) && step_valid && (head_i == val_q);
    last_step  = step_q == KW'(DEPTH - 1);
    rw_op      = (op_q == ils_pkg::MODE_GET) || (op_q == ils_pkg::MODE_SET);
    write_here = ((op_q == ils_pkg::MODE_SET) && at_pos) ||
                 ((op_q == ils_pkg::MODE_APPEND) && at_fill);
    pos_ok     = FW'(req_i.position) < FW'(fill_q);
    list_full  = fill_q == CW'(DEPTH);
  end

  // Running results including the word at the head this cycle
  always_comb begin
    rd_n    = (rw_op && at_pos) ? head_i : rd_q;
    found_n = found_q | hit;
    first_n = (hit && !found_q) ? step_q : first_q;
    cnt_n   = hit ? cnt_q + CW'(1) : cnt_q;
    fill_n  = (op_q == ils_pkg::MODE_APPEND) ? fill_q + CW'(1) : fill_q;
  end

  // Ring drive: the head word re-enters at the tail, or is replaced
  assign ring_o.shift = state_q == ST_SCAN;
  assign ring_o.tail  = write_here ? val_q : head_i;

  // Next result: immediate answers on decode, full answer after a rotation
  always_comb begin
    res_d   = res_q;
    done_d  = 1'b0;
    scan_go = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          res_d        = '0;
          res_d.length = ils_pkg::CNT_W'(fill_q);
          done_d       = 1'b1;
          unique case (req_i.mode)
            ils_pkg::MODE_APPEND: begin
              if (list_full) begin
                res_d.status = ils_pkg::STAT_FULL;
              end else begin
                scan_go = 1'b1;
                done_d  = 1'b0;
              end
            end
            ils_pkg::MODE_GET, ils_pkg::MODE_SET: begin
              if (pos_ok) begin
                scan_go = 1'b1;
                done_d  = 1'b0;
              end else begin
                res_d.status = ils_pkg::STAT_RANGE;
              end
            end
            ils_pkg::MODE_CLEAR: begin
              res_d.length = '0;
            end
            ils_pkg::MODE_FIND: begin
              scan_go = 1'b1;
              done_d  = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (last_step) begin
          done_d                = 1'b1;
          res_d                 = '0;
          res_d.read_value      = rd_n;
          res_d.found           = found_n;
          res_d.first_match_res = PW'(first_n);
          res_d.match_count     = ils_pkg::CNT_W'(cnt_n);
          res_d.length          = ils_pkg::CNT_W'(fill_n);
          res_d.status          = ils_pkg::STAT_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      fill_q  <= '0;
      op_q    <= ils_pkg::MODE_APPEND;
      pos_q   <= '0;
      val_q   <= '0;
      rd_q    <= '0;
      found_q <= 1'b0;
      first_q <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= done_d;
      res_q  <= res_d;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            op_q    <= req_i.mode;
            pos_q   <= req_i.position;
            val_q   <= req_i.value;
            step_q  <= '0;
            rd_q    <= '0;
            found_q <= 1'b0;
            first_q <= '0;
            cnt_q   <= '0;
            if (scan_go) begin
              state_q <= ST_SCAN;
            end
            if (req_i.mode == ils_pkg::MODE_CLEAR) begin
              fill_q <= '0;
            end
          end
        end
        ST_SCAN: begin
          step_q  <= step_q + KW'(1);
          rd_q    <= rd_n;
          found_q <= found_n;
          first_q <= first_n;
          cnt_q   <= cnt_n;
          if (last_step) begin
            state_q <= ST_IDLE;
            fill_q  <= fill_n;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o = state_q == ST_SCAN;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

[design/integer_list_store.sv]
// ----------------------------------------------------------------------------
// integer_list_store
// Fixed-depth list of signed 32-bit words held in a rotating ring of cells,
// with append, get, set, clear and find commands.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload   Transfer when
//  command   start / busy         req_i     start high, busy low
//  result    done_o (strobe)      res_o     done_o high, one cycle only
//
//  Append, get, set and find rotate the ring once through its single head
//  cell; after the last shift the result strobes on the next cycle and a
//  new command is taken then. No new command is taken while busy.
//  Clear, unused codes, full appends and out-of-range accesses finish without
//  a rotation. Reset clears the fill count; stored words are kept as they are.
//  The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module integer_list_store #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ils_pkg::req_t req_i,
  output logic               done_o,
  output ils_pkg::res_t      res_o
);

  ils_pkg::ring_ctl_t         ring;
  logic [ils_pkg::DATA_W-1:0] cell_q [DEPTH];

  // Ring of cells, cell 0 is the head
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    if (gi == DEPTH - 1) begin : g_tail
      ils_cell #(
        .W(ils_pkg::DATA_W)
      ) u_cell (
        .clk_i(clk_i),
        .en_i (ring.shift),
        .d_i  (ring.tail),
        .q_o  (cell_q[gi])
      );
    end else begin : g_body
      ils_cell #(
        .W(ils_pkg::DATA_W)
      ) u_cell (
        .clk_i(clk_i),
        .en_i (ring.shift),
        .d_i  (cell_q[gi+1]),
        .q_o  (cell_q[gi])
      );
    end
  end

  // Command sequencer
  ils_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .req_i  (req_i),
    .head_i (cell_q[0]),
    .ring_o (ring),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // Checks
  `ASSERT_CLK(a_accept_progress, (start && !busy) |=> (done_o || busy),
    "accepted command neither finished nor started a rotation")
  `ASSERT_IMPL(a_scan_end_result, $fell(busy), done_o,
    "rotation ended without a result")
  `ASSERT_IMPL(a_full_length, done_o && (res_o.status == ils_pkg::STAT_FULL),
    res_o.length == ils_pkg::CNT_W'(DEPTH), "full flagged below capacity")
  `ASSERT_IMPL(a_no_match_zero, done_o && !res_o.found,
    (res_o.match_count == '0) && (res_o.first_match_res == '0),
    "match fields set without a match")

endmodule

`default_nettype wire
